FILE: hdl/fla_pkg.sv
package fla_pkg;

   localparam int FREE_SLOTS_DEF = 64;
   localparam int GRANULE_DEF    = 16;
   localparam int POOL_MAX_DEF   = 65536;

   localparam int DATA_W    = 16;
   localparam int POOL_W    = 17;
   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BYTES = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NOFIT = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // one free-table entry: header offset and payload length
   typedef struct packed {
      logic [DATA_W-1:0] start;
      logic [DATA_W-1:0] len;
   } entry_type;

endpackage

FILE: hdl/fla_ram.sv
module fla_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/free_list_block_allocator_top.sv
// channel  direction  handshake              payload
// req      in         start & !busy          req_mode, req_request_bytes, req_block_offset
// rsp      out        rsp_strobe, 1 cycle    rsp_status, rsp_grant_offset, rsp_grant_bytes
// csr      in         csr_valid & csr_ready  csr_index, csr_wdata
//
// An allocate scans the free table entry by entry (registered read, then compare), up to
// the first entry that fits under first fit and over every entry under best fit, and
// removes a wholly granted entry by moving each later entry down (read, then write).
// A free reads the granted size, scans to the insert point, merges with neighbours or
// shifts the table; a bad offset is answered without a scan. After reset the S_INIT
// state writes the initial free block (busy high). The receiver cannot stall; csr_ready
// is always high. GRANULE must be a power of two.
module free_list_block_allocator_top #(
   parameter int FREE_SLOTS = fla_pkg::FREE_SLOTS_DEF,
   parameter int GRANULE    = fla_pkg::GRANULE_DEF,
   parameter int POOL_MAX   = fla_pkg::POOL_MAX_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_mode,
   input  logic [fla_pkg::DATA_W-1:0]     req_request_bytes,
   input  logic [fla_pkg::DATA_W-1:0]     req_block_offset,
   output logic                           rsp_strobe,
   output logic [1:0]                     rsp_status,
   output logic [fla_pkg::DATA_W-1:0]     rsp_grant_offset,
   output logic [fla_pkg::DATA_W-1:0]     rsp_grant_bytes,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fla_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fla_pkg::POOL_W-1:0]     csr_wdata
);

   localparam int DW          = fla_pkg::DATA_W;
   localparam int PW          = fla_pkg::POOL_W;
   localparam int IW          = $clog2(FREE_SLOTS + 1);
   localparam int AW          = $clog2(FREE_SLOTS);
   localparam int GSH         = $clog2(GRANULE);
   localparam int STORE_DEPTH = POOL_MAX / GRANULE;
   localparam int SAW         = $clog2(STORE_DEPTH);
   localparam int IXW         = (SAW > PW) ? SAW : PW;
   localparam int POOL_TOP    = (POOL_MAX < 65536) ? POOL_MAX : 65536;

   typedef enum logic [11:0] {
      S_INIT = 12'b0000_0000_0001,
      S_IDLE = 12'b0000_0000_0010,
      S_ARD  = 12'b0000_0000_0100,
      S_ACHK = 12'b0000_0000_1000,
      S_AFIN = 12'b0000_0001_0000,
      S_FST  = 12'b0000_0010_0000,
      S_FRD  = 12'b0000_0100_0000,
      S_FCHK = 12'b0000_1000_0000,
      S_FAPP = 12'b0001_0000_0000,
      S_SHRD = 12'b0010_0000_0000,
      S_SHWR = 12'b0100_0000_0000,
      S_RESP = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic          fit_ff, fit_in;
   logic [PW-1:0] pool_ff, pool_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] i_ff, i_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic          found_ff, found_in;
   logic          has_next_ff, has_next_in;
   logic          dn_ff, dn_in;
   logic [PW-1:0] need_ff, need_in;
   logic [DW-1:0] off_ff, off_in;
   logic [DW-1:0] len_ff, len_in;
   fla_pkg::entry_type pick_ff, pick_in;
   fla_pkg::entry_type prev_ff, prev_in;
   fla_pkg::entry_type next_ff, next_in;
   fla_pkg::status_type res_status_ff, res_status_in;
   logic [DW-1:0] res_off_ff, res_off_in;
   logic [DW-1:0] res_bytes_ff, res_bytes_in;

   // table RAM
   logic               tbl_we;
   logic [AW-1:0]      tbl_waddr, tbl_raddr;
   fla_pkg::entry_type tbl_wdata, tbl_rdata;

   // granted-size RAM
   logic           st_we;
   logic [SAW-1:0] st_waddr, st_raddr;
   logic [DW-1:0]  st_wdata, st_rdata;

   fla_ram #(.WIDTH(2 * DW), .DEPTH(FREE_SLOTS)) u_tbl (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   fla_ram #(.WIDTH(DW), .DEPTH(STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   logic          csr_wr, pool_wr;
   logic [PW-1:0] clamp_v, pool_new;
   logic [DW-1:0] hdr;
   logic [IW-1:0] i_inc, i_dec;
   logic [PW-1:0] sum_sg;
   logic [IXW-1:0] st_idx_a, st_idx_f;
   logic           split, fits, take, bad_off, mprev, mnext;
   logic [PW:0]    prev_end;
   logic [PW-1:0]  off_end_in, off_end;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;
   assign pool_wr   = csr_wr && (csr_index == fla_pkg::CSR_POOL_BYTES);

   always_comb begin
      clamp_v = csr_wdata;
      if (clamp_v > PW'(POOL_TOP)) clamp_v = PW'(POOL_TOP);
      if (clamp_v < PW'(2 * GRANULE)) clamp_v = PW'(2 * GRANULE);
      clamp_v = (clamp_v >> GSH) << GSH;
   end

   assign pool_new = pool_wr ? clamp_v : pool_ff;
   assign hdr      = off_ff - DW'(GRANULE);
   assign i_inc    = i_ff + IW'(1);
   assign i_dec    = i_ff - IW'(1);
   assign sum_sg   = {1'b0, pick_ff.start} + PW'(GRANULE);
   assign st_idx_a = IXW'(sum_sg >> GSH);
   assign st_idx_f = IXW'(req_block_offset >> GSH);
   assign st_raddr = st_idx_f[SAW-1:0];
   assign split    = {2'b0, pick_ff.len} >= ({1'b0, need_ff} + (PW + 1)'(GRANULE + 1));
   assign fits     = {1'b0, tbl_rdata.len} >= need_ff;
   assign take     = fits && (!found_ff || (fit_ff && tbl_rdata.len < pick_ff.len));
   assign bad_off  = (req_block_offset < DW'(GRANULE)) ||
                     (req_block_offset[GSH-1:0] != '0) ||
                     (st_idx_f >= IXW'(STORE_DEPTH));
   assign off_end_in = {1'b0, off_ff} + {1'b0, st_rdata};
   assign off_end    = {1'b0, off_ff} + {1'b0, len_ff};
   assign prev_end   = {2'b0, prev_ff.start} + (PW + 1)'(GRANULE) + {2'b0, prev_ff.len};
   assign mprev      = (pos_ff != '0) && (prev_end == {2'b0, hdr});
   assign mnext      = has_next_ff && (off_end == {1'b0, next_ff.start});

   always_comb begin
      state_in      = state_ff;
      fit_in        = fit_ff;
      pool_in       = pool_ff;
      cnt_in        = cnt_ff;
      i_in          = i_ff;
      pos_in        = pos_ff;
      found_in      = found_ff;
      has_next_in   = has_next_ff;
      dn_in         = dn_ff;
      need_in       = need_ff;
      off_in        = off_ff;
      len_in        = len_ff;
      pick_in       = pick_ff;
      prev_in       = prev_ff;
      next_in       = next_ff;
      res_status_in = res_status_ff;
      res_off_in    = res_off_ff;
      res_bytes_in  = res_bytes_ff;
      tbl_we        = 1'b0;
      tbl_waddr     = i_ff[AW-1:0];
      tbl_wdata     = tbl_rdata;
      tbl_raddr     = i_ff[AW-1:0];
      st_we         = 1'b0;
      st_waddr      = st_idx_a[SAW-1:0];
      st_wdata      = '0;

      if (csr_wr && (csr_index == fla_pkg::CSR_FIT_POLICY)) fit_in = csr_wdata[0];
      if (pool_wr) begin
         pool_in = clamp_v;
         cnt_in  = IW'(1);
      end

      unique case (state_ff)
         S_INIT: begin
            state_in = S_IDLE;
            cnt_in   = IW'(1);
         end
         S_IDLE: begin
            if (start) begin
               res_status_in = fla_pkg::ST_OK;
               res_off_in    = '0;
               res_bytes_in  = '0;
               i_in          = '0;
               found_in      = 1'b0;
               has_next_in   = 1'b0;
               off_in        = req_block_offset;
               need_in       = (({1'b0, req_request_bytes} + PW'(GRANULE - 1)) >> GSH) << GSH;
               if (!req_mode) begin
                  state_in = S_ARD;
               end else if (bad_off) begin
                  res_status_in = fla_pkg::ST_NOFIT;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_FST;
               end
            end
         end
         S_ARD: begin
            state_in = (i_ff < cnt_ff) ? S_ACHK : S_AFIN;
         end
         S_ACHK: begin
            if (take) begin
               pick_in  = tbl_rdata;
               pos_in   = i_ff;
               found_in = 1'b1;
            end
            if (fits && !fit_ff) begin
               state_in = S_AFIN;
            end else begin
               i_in     = i_inc;
               state_in = S_ARD;
            end
         end
         S_AFIN: begin
            if (!found_ff) begin
               res_status_in = fla_pkg::ST_NOFIT;
               state_in      = S_RESP;
            end else begin
               res_off_in   = sum_sg[DW-1:0];
               res_bytes_in = split ? need_ff[DW-1:0] : pick_ff.len;
               st_we        = st_idx_a < IXW'(STORE_DEPTH);
               st_wdata     = split ? need_ff[DW-1:0] : pick_ff.len;
               if (split) begin
                  tbl_we          = 1'b1;
                  tbl_waddr       = pos_ff[AW-1:0];
                  tbl_wdata.start = DW'(sum_sg + need_ff);
                  tbl_wdata.len   = DW'({1'b0, pick_ff.len} - need_ff - PW'(GRANULE));
                  state_in        = S_RESP;
               end else begin
                  i_in     = pos_ff;
                  dn_in    = 1'b1;
                  state_in = S_SHRD;
               end
            end
         end
         S_FST: begin
            len_in = st_rdata;
            if (off_end_in > pool_ff) begin
               res_status_in = fla_pkg::ST_NOFIT;
               state_in      = S_RESP;
            end else begin
               state_in = S_FRD;
            end
         end
         S_FRD: begin
            if (i_ff < cnt_ff) begin
               state_in = S_FCHK;
            end else begin
               pos_in   = i_ff;
               state_in = S_FAPP;
            end
         end
         S_FCHK: begin
            if (tbl_rdata.start <= hdr) begin
               prev_in  = tbl_rdata;
               i_in     = i_inc;
               state_in = S_FRD;
            end else begin
               next_in     = tbl_rdata;
               has_next_in = 1'b1;
               pos_in      = i_ff;
               state_in    = S_FAPP;
            end
         end
         S_FAPP: begin
            tbl_wdata = prev_ff;
            tbl_waddr = AW'(pos_ff - IW'(1));
            priority if (mprev && mnext) begin
               tbl_we        = 1'b1;
               tbl_wdata.len = DW'(prev_ff.len + DW'(2 * GRANULE) + len_ff + next_ff.len);
               i_in          = pos_ff;
               dn_in         = 1'b1;
               state_in      = S_SHRD;
            end else if (mprev) begin
               tbl_we        = 1'b1;
               tbl_wdata.len = DW'(prev_ff.len + DW'(GRANULE) + len_ff);
               state_in      = S_RESP;
            end else if (mnext) begin
               tbl_we          = 1'b1;
               tbl_waddr       = pos_ff[AW-1:0];
               tbl_wdata.start = hdr;
               tbl_wdata.len   = DW'(next_ff.len + DW'(GRANULE) + len_ff);
               state_in        = S_RESP;
            end else if (cnt_ff >= IW'(FREE_SLOTS)) begin
               res_status_in = fla_pkg::ST_FULL;
               state_in      = S_RESP;
            end else begin
               i_in     = cnt_ff;
               dn_in    = 1'b0;
               state_in = S_SHRD;
            end
         end
         S_SHRD: begin
            // remove shifts entries down from pos, insert shifts them up to pos
            if (dn_ff) begin
               tbl_raddr = i_inc[AW-1:0];
               if (i_inc < cnt_ff) begin
                  state_in = S_SHWR;
               end else begin
                  cnt_in   = cnt_ff - IW'(1);
                  state_in = S_RESP;
               end
            end else begin
               tbl_raddr = i_dec[AW-1:0];
               if (i_ff > pos_ff) begin
                  state_in = S_SHWR;
               end else begin
                  tbl_we          = 1'b1;
                  tbl_waddr       = pos_ff[AW-1:0];
                  tbl_wdata.start = hdr;
                  tbl_wdata.len   = len_ff;
                  cnt_in          = cnt_ff + IW'(1);
                  state_in        = S_RESP;
               end
            end
         end
         S_SHWR: begin
            tbl_we    = 1'b1;
            tbl_waddr = i_ff[AW-1:0];
            tbl_wdata = tbl_rdata;
            i_in      = dn_ff ? i_inc : i_dec;
            state_in  = S_SHRD;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // initial free block after reset or pool write; user keeps writes to idle
      if (pool_wr || state_ff == S_INIT) begin
         tbl_we          = 1'b1;
         tbl_waddr       = '0;
         tbl_wdata.start = '0;
         tbl_wdata.len   = DW'(pool_new - PW'(GRANULE));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         fit_ff   <= 1'b0;
         pool_ff  <= PW'(POOL_TOP);
         cnt_ff   <= IW'(1);
      end else begin
         state_ff <= state_in;
         fit_ff   <= fit_in;
         pool_ff  <= pool_in;
         cnt_ff   <= cnt_in;
      end
      i_ff          <= i_in;
      pos_ff        <= pos_in;
      found_ff      <= found_in;
      has_next_ff   <= has_next_in;
      dn_ff         <= dn_in;
      need_ff       <= need_in;
      off_ff        <= off_in;
      len_ff        <= len_in;
      pick_ff       <= pick_in;
      prev_ff       <= prev_in;
      next_ff       <= next_in;
      res_status_ff <= res_status_in;
      res_off_ff    <= res_off_in;
      res_bytes_ff  <= res_bytes_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = (state_ff == S_RESP);
   assign rsp_status       = res_status_ff;
   assign rsp_grant_offset = res_off_ff;
   assign rsp_grant_bytes  = res_bytes_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= IW'(FREE_SLOTS))
      else $error("free count above table size");

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result beat longer than one cycle");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_full_cnt: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == fla_pkg::ST_FULL) |-> (cnt_ff == IW'(FREE_SLOTS)))
      else $error("table full reported with room left");

endmodule
